FILE: sv/tilt_pkg.sv
// Package: shared constants, types and tables for the tilt angle estimator.
`timescale 1ns / 1ps
package tilt_pkg;
    localparam int SAMPLE_WIDTH  = 16;
    localparam int FRACTION_BITS = 8;
    localparam int CORDIC_STEPS  = 16;
    localparam int ANGLE_W       = 15;
    localparam int SHIFT_W       = 3;
    localparam int ATAN_LEN      = 24;
    localparam int MAX_WORK      = 31;
    localparam int ZACC_W        = 26;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd1;

    typedef enum logic [2:0] {
        S_IDLE, S_FILT, S_SQRT, S_PREP, S_ROT, S_DONE, S_OUT
    } t_state;

    function automatic logic [ZACC_W-1:0] atan_lut(input logic [4:0] i);
        logic [ZACC_W-1:0] v;
        case (i)
            5'd0:  v = 26'd2949120;
            5'd1:  v = 26'd1740967;
            5'd2:  v = 26'd919879;
            5'd3:  v = 26'd466945;
            5'd4:  v = 26'd234379;
            5'd5:  v = 26'd117304;
            5'd6:  v = 26'd58666;
            5'd7:  v = 26'd29335;
            5'd8:  v = 26'd14668;
            5'd9:  v = 26'd7334;
            5'd10: v = 26'd3667;
            5'd11: v = 26'd1833;
            5'd12: v = 26'd917;
            5'd13: v = 26'd458;
            5'd14: v = 26'd229;
            5'd15: v = 26'd115;
            5'd16: v = 26'd57;
            5'd17: v = 26'd29;
            5'd18: v = 26'd14;
            5'd19: v = 26'd7;
            5'd20: v = 26'd4;
            5'd21: v = 26'd2;
            5'd22: v = 26'd1;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage

FILE: sv/tilt_if.sv
// Interfaces: valid/ready channels for samples, angles and configuration.
`timescale 1ns / 1ps
interface tilt_in_if #(parameter int W = tilt_pkg::SAMPLE_WIDTH);
    logic valid;
    logic ready;
    logic signed [W-1:0] accel_x;
    logic signed [W-1:0] accel_y;
    logic signed [W-1:0] accel_z;
    modport source(output valid, accel_x, accel_y, accel_z, input ready);
    modport sink(input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface tilt_out_if;
    logic valid;
    logic ready;
    logic signed [tilt_pkg::ANGLE_W-1:0] roll_angle;
    logic signed [tilt_pkg::ANGLE_W-1:0] pitch_angle;
    logic [tilt_pkg::ANGLE_W-1:0] incline_angle;
    modport source(output valid, roll_angle, pitch_angle, incline_angle, input ready);
    modport sink(input valid, roll_angle, pitch_angle, incline_angle, output ready);
endinterface

interface tilt_cfg_if;
    logic valid;
    logic ready;
    logic [tilt_pkg::SHIFT_W-1:0] data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

FILE: sv/accel_tilt_angle_estimator.sv
// Top level: filters three axes and computes roll, pitch and incline angles.
// The work width W is 24 bits at the defaults. Each sample takes three passes
// through one shared unit, each running a bit-serial square root (one result
// bit per cycle) and then one CORDIC rotation per cycle. A pass whose angle
// is an axis or zero-vector case skips the rotations and is shorter. The block is
// not ready while a sample is in flight or its result waits at the output register.
`timescale 1ns / 1ps
module accel_tilt_angle_estimator #(
    parameter int SAMPLE_WIDTH  = tilt_pkg::SAMPLE_WIDTH,
    parameter int FRACTION_BITS = tilt_pkg::FRACTION_BITS,
    parameter int CORDIC_STEPS  = tilt_pkg::CORDIC_STEPS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tilt_in_if.sink   i_sample,
    tilt_out_if.source o_angles,
    tilt_cfg_if.sink  i_cfg
);
    localparam int FW  = SAMPLE_WIDTH + FRACTION_BITS;
    localparam int PRE = (FW > tilt_pkg::MAX_WORK) ? FW - tilt_pkg::MAX_WORK : 0;
    localparam int WW  = FW - PRE;
    localparam int AW  = tilt_pkg::ANGLE_W;

    tilt_pkg::t_state r_st, n_st;
    logic [tilt_pkg::SHIFT_W-1:0] r_shift;
    logic signed [FW-1:0] r_fx, r_fy, r_fz;
    logic signed [SAMPLE_WIDTH-1:0] r_sx, r_sy, r_sz;
    logic [1:0] r_pass;
    logic signed [AW-1:0] r_roll, r_pitch;
    logic [AW-1:0] r_incl;
    logic r_ovalid;
    logic w_start, w_done, w_num;
    logic signed [WW-1:0] w_px, w_py, w_pz, w_a, w_b, w_o;
    logic signed [AW:0] w_ang;

    function automatic logic signed [FW-1:0] smooth(input logic signed [FW-1:0] f,
            input logic signed [SAMPLE_WIDTH-1:0] s, input logic [2:0] sh);
        logic signed [FW:0] d;
        d = (FW+1)'($signed({s, {FRACTION_BITS{1'b0}}})) - (FW+1)'(f);
        return FW'((FW+1)'(f) + (d >>> sh));
    endfunction

    assign w_px = WW'(r_fx >>> PRE);
    assign w_py = WW'(r_fy >>> PRE);
    assign w_pz = WW'(r_fz >>> PRE);

    always_comb begin
        case (r_pass)
            2'd0:    begin w_a = w_px; w_b = w_pz; w_o = w_py; w_num = 1'b0; end
            2'd1:    begin w_a = w_py; w_b = w_pz; w_o = w_px; w_num = 1'b0; end
            default: begin w_a = w_px; w_b = w_py; w_o = w_pz; w_num = 1'b1; end
        endcase
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            tilt_pkg::S_IDLE: if (i_sample.valid) n_st = tilt_pkg::S_FILT;
            tilt_pkg::S_FILT: n_st = tilt_pkg::S_PREP;
            tilt_pkg::S_PREP: n_st = tilt_pkg::S_ROT;
            tilt_pkg::S_ROT: begin
                if (w_done) n_st = (r_pass == 2'd2) ? tilt_pkg::S_OUT : tilt_pkg::S_PREP;
            end
            tilt_pkg::S_OUT: if (o_angles.ready) n_st = tilt_pkg::S_IDLE;
            default: n_st = tilt_pkg::S_IDLE;
        endcase
    end

    assign w_start = (r_st == tilt_pkg::S_PREP);
    assign i_sample.ready = (r_st == tilt_pkg::S_IDLE);
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= tilt_pkg::S_IDLE;
            r_shift <= tilt_pkg::SHIFT_RESET;
            r_fx <= '0; r_fy <= '0; r_fz <= '0;
            r_pass <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg.valid) r_shift <= i_cfg.data;
            if (r_st == tilt_pkg::S_FILT) begin
                r_fx <= smooth(r_fx, r_sx, r_shift);
                r_fy <= smooth(r_fy, r_sy, r_shift);
                r_fz <= smooth(r_fz, r_sz, r_shift);
                r_pass <= '0;
            end
            if (r_st == tilt_pkg::S_ROT && w_done) r_pass <= r_pass + 1'b1;
            r_ovalid <= (n_st == tilt_pkg::S_OUT);
        end
        if (i_sample.valid && i_sample.ready) begin
            r_sx <= i_sample.accel_x; r_sy <= i_sample.accel_y; r_sz <= i_sample.accel_z;
        end
        if (r_st == tilt_pkg::S_ROT && w_done) begin
            case (r_pass)
                2'd0: r_roll <= (w_ang > 16'sd11520) ? 15'sd11520 :
                                (w_ang < -16'sd11520) ? -15'sd11520 : AW'(w_ang);
                2'd1: r_pitch <= (w_ang > 16'sd11520) ? 15'sd11520 :
                                 (w_ang < -16'sd11520) ? -15'sd11520 : AW'(w_ang);
                default: r_incl <= (w_ang > 16'sd23040) ? 15'd23040 :
                                   (w_ang < 0) ? 15'd0 : AW'(w_ang);
            endcase
        end
    end

    tilt_cordic #(.WW(WW), .STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_mag_is_num(w_num),
        .i_a(w_a), .i_b(w_b), .i_other(w_o), .o_done(w_done), .o_angle(w_ang)
    );

    assign o_angles.valid = r_ovalid;
    assign o_angles.roll_angle = r_roll;
    assign o_angles.pitch_angle = r_pitch;
    assign o_angles.incline_angle = r_incl;

    a_valid_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_st == tilt_pkg::S_OUT)) else $error("valid outside output state");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != tilt_pkg::S_IDLE) |-> !i_sample.ready) else $error("ready while busy");
    a_pass_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == tilt_pkg::S_ROT) |-> (r_pass != 2'd3)) else $error("pass overrun");
endmodule

FILE: sv/tilt_cordic.sv
// Iterative unit: bit-serial integer square root then vectoring CORDIC atan2.
`timescale 1ns / 1ps
module tilt_cordic #(
    parameter int WW    = 31,
    parameter int STEPS = tilt_pkg::CORDIC_STEPS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_mag_is_num,
    input  logic signed [WW-1:0]  i_a,
    input  logic signed [WW-1:0]  i_b,
    input  logic signed [WW-1:0]  i_other,
    output logic                  o_done,
    output logic signed [tilt_pkg::ANGLE_W:0] o_angle
);
    localparam int SQ_W  = 2 * WW;
    localparam int RT_W  = WW + 1;
    localparam int XW    = WW + 4;
    localparam int ZW    = tilt_pkg::ZACC_W + 1;
    localparam int CAP   = (STEPS < tilt_pkg::ATAN_LEN) ? STEPS : tilt_pkg::ATAN_LEN;
    localparam int CNT_W = $clog2(SQ_W + 2);

    tilt_pkg::t_state r_st, n_st;
    logic [SQ_W-1:0]          r_rem, n_rem;
    logic [SQ_W-1:0]          r_res, n_res;
    logic [SQ_W-1:0]          r_bit, n_bit;
    logic signed [XW-1:0]     r_x, n_x, r_y, n_y;
    logic signed [ZW-1:0]     r_z, n_z;
    logic [CNT_W-1:0]         r_i, n_i;
    logic                     r_num, n_num;
    logic signed [WW-1:0]     r_oth;
    logic [SQ_W-1:0]          w_sum;
    logic [WW-1:0]            w_ua, w_ub;
    logic signed [XW-1:0]     w_mag, w_yv, w_xv, w_dx, w_dy;
    logic signed [ZW-1:0]     w_atan, w_rnd;
    logic signed [tilt_pkg::ANGLE_W:0] r_ang, n_ang;
    logic                     r_done, n_done;

    assign w_ua  = i_a[WW-1] ? WW'(-i_a) : WW'(i_a);
    assign w_ub  = i_b[WW-1] ? WW'(-i_b) : WW'(i_b);
    assign w_sum = SQ_W'(w_ua * w_ua) + SQ_W'(w_ub * w_ub);
    assign w_mag = XW'($signed({1'b0, r_res[RT_W-1:0]}));
    assign w_yv  = r_num ? w_mag : XW'(r_oth);
    assign w_xv  = r_num ? XW'(r_oth) : w_mag;
    assign w_dx  = r_y >>> r_i;
    assign w_dy  = r_x >>> r_i;
    assign w_atan = ZW'(tilt_pkg::atan_lut(r_i[4:0]));
    assign w_rnd  = (r_z + ZW'(256)) >>> 9;

    always_comb begin
        n_st = r_st; n_rem = r_rem; n_res = r_res; n_bit = r_bit;
        n_x = r_x; n_y = r_y; n_z = r_z; n_i = r_i; n_num = r_num;
        n_ang = r_ang; n_done = 1'b0;
        case (r_st)
            tilt_pkg::S_IDLE: begin
                if (i_start) begin
                    n_rem = w_sum; n_res = '0; n_num = i_mag_is_num;
                    n_bit = SQ_W'(1) << (SQ_W - 2);
                    n_st = tilt_pkg::S_SQRT;
                end
            end
            tilt_pkg::S_SQRT: begin
                if (r_bit == '0) begin
                    n_st = tilt_pkg::S_PREP;
                end else begin
                    if (r_rem >= r_res + r_bit) begin
                        n_rem = r_rem - (r_res + r_bit);
                        n_res = (r_res >> 1) + r_bit;
                    end else begin
                        n_res = r_res >> 1;
                    end
                    n_bit = r_bit >> 2;
                end
            end
            tilt_pkg::S_PREP: begin
                n_i = '0; n_z = '0; n_x = w_xv; n_y = w_yv;
                n_st = tilt_pkg::S_ROT;
                if (w_yv == '0) begin
                    n_ang = (w_xv < 0) ? 16'sd23040 : 16'sd0;
                    n_st = tilt_pkg::S_OUT;
                end else if (w_xv == '0) begin
                    n_ang = (w_yv > 0) ? 16'sd11520 : -16'sd11520;
                    n_st = tilt_pkg::S_OUT;
                end else if (w_xv < 0) begin
                    if (w_yv > 0) begin
                        n_x = w_yv; n_y = -w_xv; n_z = ZW'(90 * 65536);
                    end else begin
                        n_x = -w_yv; n_y = w_xv; n_z = -ZW'(90 * 65536);
                    end
                end
            end
            tilt_pkg::S_ROT: begin
                if (r_i == CNT_W'(CAP)) begin
                    n_st = tilt_pkg::S_DONE;
                end else begin
                    if (r_y > 0) begin
                        n_x = r_x + w_dx; n_y = r_y - w_dy; n_z = r_z + w_atan;
                    end else begin
                        n_x = r_x - w_dx; n_y = r_y + w_dy; n_z = r_z - w_atan;
                    end
                    n_i = r_i + 1'b1;
                end
            end
            tilt_pkg::S_DONE: begin
                n_ang = (tilt_pkg::ANGLE_W + 1)'(w_rnd);
                n_st = tilt_pkg::S_OUT;
            end
            tilt_pkg::S_OUT: begin
                n_done = 1'b1;
                n_st = tilt_pkg::S_IDLE;
            end
            default: n_st = tilt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= tilt_pkg::S_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st <= n_st;
            r_done <= n_done;
        end
        r_rem <= n_rem; r_res <= n_res; r_bit <= n_bit;
        r_x <= n_x; r_y <= n_y; r_z <= n_z; r_i <= n_i; r_num <= n_num;
        r_ang <= n_ang;
        if (r_st == tilt_pkg::S_IDLE && i_start) r_oth <= i_other;
    end

    assign o_done  = r_done;
    assign o_angle = r_ang;

    a_done_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == tilt_pkg::S_OUT) |=> r_done) else $error("done missing");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done not a pulse");
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == tilt_pkg::S_ROT) |-> (r_i <= CNT_W'(CAP))) else $error("step overrun");
endmodule

FILE: sim/tb.sv
// Testbench: drives accelerometer samples and smoothing settings, checks tilt angles.
`timescale 1ns / 1ps
module tb;
    typedef struct packed {
        logic signed [tilt_pkg::ANGLE_W-1:0] roll;
        logic signed [tilt_pkg::ANGLE_W-1:0] pitch;
        logic [tilt_pkg::ANGLE_W-1:0]        incline;
    } t_angles;

    typedef struct {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        bit                 known;
        t_angles            ang;
    } t_row;

    localparam int SETTLE_CYCLES = 400;
    localparam int WATCHDOG_MAX  = 20000;
    localparam int HOLD_CYCLES   = 600;

    logic i_clk;
    logic i_rst_n;

    tilt_in_if  smp_if();
    tilt_out_if ang_if();
    tilt_cfg_if cfg_if();

    accel_tilt_angle_estimator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sample(smp_if.sink),
        .o_angles(ang_if.source),
        .i_cfg   (cfg_if.sink)
    );

    int unsigned       filt_shift;
    longint            filt_x, filt_y, filt_z;
    t_angles           angle_queue[$];
    int                n_errors;
    int                n_samples;
    int                n_angles;
    int                idle_count;
    bit                sink_calm;
    bit                hold_off;
    bit                stim_done;

    longint atan_q16[tilt_pkg::ATAN_LEN] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint vec_len(longint a, longint b);
        if (a < 0) a = -a;
        if (b < 0) b = -b;
        return int_sqrt(a * a + b * b);
    endfunction

    function automatic longint atan2_deg128(longint y, longint x);
        longint z;
        longint t;
        longint dx;
        longint dy;
        z = 0;
        if (y == 0) return (x < 0) ? 180 * 128 : 0;
        if (x == 0) return (y > 0) ? 90 * 128 : -90 * 128;
        if (x < 0) begin
            if (y > 0) begin
                t = x; x = y; y = -t; z = 64'sd90 <<< 16;
            end else begin
                t = x; x = -y; y = t; z = -(64'sd90 <<< 16);
            end
        end
        for (int i = 0; i < tilt_pkg::CORDIC_STEPS && i < tilt_pkg::ATAN_LEN; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += atan_q16[i];
            end else begin
                x -= dx; y += dy; z -= atan_q16[i];
            end
        end
        return floor_shift(z + 256, 9);
    endfunction

    function automatic longint limit(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic t_angles tilt_predict(logic signed [15:0] ax, logic signed [15:0] ay,
                                             logic signed [15:0] az);
        t_angles a;
        longint  fx, fy, fz;
        int      pre;
        filt_x += floor_shift((longint'(ax) <<< tilt_pkg::FRACTION_BITS) - filt_x, filt_shift);
        filt_y += floor_shift((longint'(ay) <<< tilt_pkg::FRACTION_BITS) - filt_y, filt_shift);
        filt_z += floor_shift((longint'(az) <<< tilt_pkg::FRACTION_BITS) - filt_z, filt_shift);
        pre = (tilt_pkg::SAMPLE_WIDTH + tilt_pkg::FRACTION_BITS > tilt_pkg::MAX_WORK) ?
              tilt_pkg::SAMPLE_WIDTH + tilt_pkg::FRACTION_BITS - tilt_pkg::MAX_WORK : 0;
        fx = floor_shift(filt_x, pre);
        fy = floor_shift(filt_y, pre);
        fz = floor_shift(filt_z, pre);
        a.roll    = (tilt_pkg::ANGLE_W)'(limit(atan2_deg128(fy, vec_len(fx, fz)),
                                               -11520, 11520));
        a.pitch   = (tilt_pkg::ANGLE_W)'(limit(atan2_deg128(fx, vec_len(fy, fz)),
                                               -11520, 11520));
        a.incline = (tilt_pkg::ANGLE_W)'(limit(atan2_deg128(vec_len(fx, fy), fz), 0, 23040));
        return a;
    endfunction

    task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                               logic signed [15:0] az, bit known, t_angles ang, bit gaps);
        t_angles p;
        if (gaps && $urandom_range(0, 3) == 0) begin
            smp_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        smp_if.valid   <= 1'b1;
        smp_if.accel_x <= ax;
        smp_if.accel_y <= ay;
        smp_if.accel_z <= az;
        @(posedge i_clk);
        while (!smp_if.ready) @(posedge i_clk);
        p = tilt_predict(ax, ay, az);
        if (known && p !== ang) begin
            $display("%0t table row disagrees with predictor: table %h predicted %h",
                     $time, ang, p);
            n_errors++;
        end
        angle_queue.push_back(p);
        n_samples++;
    endtask

    task automatic drain();
        smp_if.valid <= 1'b0;
        while (angle_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_shift(logic [tilt_pkg::SHIFT_W-1:0] v);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        filt_shift = v;
    endtask

    // Output side: random stalls, checks against the oldest expectation.
    initial begin
        ang_if.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_off) begin
                ang_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (!sink_calm && $urandom_range(0, 3) == 0) begin
                ang_if.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            ang_if.ready <= 1'b1;
            @(posedge i_clk);
            if (ang_if.valid && ang_if.ready) begin
                n_angles++;
                if (angle_queue.size() == 0) begin
                    $display("%0t unexpected transaction: actual %0d %0d %0d", $time,
                             ang_if.roll_angle, ang_if.pitch_angle, ang_if.incline_angle);
                    n_errors++;
                end else begin
                    t_angles e;
                    e = angle_queue.pop_front();
                    if (ang_if.roll_angle !== e.roll) begin
                        $display("%0t roll: expected %0d actual %0d", $time, e.roll,
                                 ang_if.roll_angle);
                        n_errors++;
                    end
                    if (ang_if.pitch_angle !== e.pitch) begin
                        $display("%0t pitch: expected %0d actual %0d", $time, e.pitch,
                                 ang_if.pitch_angle);
                        n_errors++;
                    end
                    if (ang_if.incline_angle !== e.incline) begin
                        $display("%0t incline: expected %0d actual %0d", $time, e.incline,
                                 ang_if.incline_angle);
                        n_errors++;
                    end
                end
            end
        end
    end

    // Watchdog: cycles with no accepted transaction on any channel.
    initial begin
        idle_count = 0;
        forever begin
            @(posedge i_clk);
            if ((smp_if.valid && smp_if.ready) || (ang_if.valid && ang_if.ready) ||
                (cfg_if.valid && cfg_if.ready) || stim_done)
                idle_count = 0;
            else
                idle_count++;
            if (idle_count >= WATCHDOG_MAX) begin
                $display("%0t watchdog expired, %0d transactions pending", $time,
                         angle_queue.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        t_row    rows[$];
        t_angles nul;
        logic signed [15:0] ax, ay, az;
        int      kind;
        int      timer;

        nul = '0;
        i_rst_n = 1'b0;
        smp_if.valid = 1'b0;
        smp_if.accel_x = '0;
        smp_if.accel_y = '0;
        smp_if.accel_z = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        filt_shift = tilt_pkg::SHIFT_RESET;
        filt_x = 0; filt_y = 0; filt_z = 0;
        n_errors = 0; n_samples = 0; n_angles = 0;
        sink_calm = 1'b0; hold_off = 1'b0; stim_done = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero vector, axis extremes, sign combinations, shift 0 and shift 7 loads.
        rows.push_back('{16'sd0, 16'sd0, 16'sd0, 1'b1, nul});
        rows.push_back('{16'sd0, 16'sd0, 16'sd16384, 1'b1, '{15'sd0, 15'sd0, 15'd0}});
        rows.push_back('{16'sd0, 16'sd0, -16'sd32768, 1'b0, nul});
        rows.push_back('{16'sd0, 16'sd0, -16'sd32768, 1'b0, nul});
        foreach (rows[i]) send_sample(rows[i].ax, rows[i].ay, rows[i].az,
                                      rows[i].known, rows[i].ang, 1'b0);
        drain();
        rows.delete();
        write_shift(3'd0);
        rows.push_back('{16'sd0, 16'sd0, 16'sd0, 1'b1, nul});
        rows.push_back('{16'sd0, 16'sd0, 16'sd100, 1'b1, nul});
        rows.push_back('{16'sd0, 16'sd0, -16'sd100, 1'b1, '{15'sd0, 15'sd0, 15'd23040}});
        rows.push_back('{16'sd0, 16'sd100, 16'sd0, 1'b1, '{15'sd11520, 15'sd0, 15'd11520}});
        rows.push_back('{16'sd0, -16'sd100, 16'sd0, 1'b1, '{-15'sd11520, 15'sd0, 15'd11520}});
        rows.push_back('{16'sd32767, 16'sd0, 16'sd0, 1'b1, '{15'sd0, 15'sd11520, 15'd11520}});
        rows.push_back('{-16'sd32768, 16'sd0, 16'sd0, 1'b1, '{15'sd0, -15'sd11520, 15'd11520}});
        rows.push_back('{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, nul});
        rows.push_back('{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, nul});
        rows.push_back('{16'sd32767, -16'sd32768, 16'sd1, 1'b0, nul});
        rows.push_back('{-16'sd1, 16'sd1, -16'sd1, 1'b0, nul});
        rows.push_back('{16'sd5, -16'sd7, -16'sd30000, 1'b0, nul});
        rows.push_back('{16'sd1, 16'sd0, -16'sd1, 1'b0, nul});
        foreach (rows[i]) send_sample(rows[i].ax, rows[i].ay, rows[i].az,
                                      rows[i].known, rows[i].ang, 1'b0);
        drain();
        write_shift(3'd7);
        for (int i = 0; i < 6; i++)
            send_sample(16'sd32767, -16'sd32768, 16'sd20000, 1'b0, nul, 1'b0);

        // Random: one phase per shift; long output hold in phase 2, steady flow in phase 7.
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            write_shift((tilt_pkg::SHIFT_W)'(ph));
            if (ph == 2) hold_off = 1'b1;
            if (ph == 7) sink_calm = 1'b1;
            for (int n = 0; n < 135; n++) begin
                kind = $urandom_range(0, 9);
                ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
                if (kind < 5) begin
                    ax = 16'($urandom_range(0, 4000) - 2000);
                    ay = 16'($urandom_range(0, 4000) - 2000);
                    az = 16'(16'sd16384 + $urandom_range(0, 800) - 400);
                    if ($urandom_range(0, 1)) az = -az;
                end else if (kind == 5) begin
                    ax = $urandom_range(0, 1) ? 16'sd0 : ax;
                    ay = $urandom_range(0, 1) ? 16'sd0 : ay;
                    az = $urandom_range(0, 1) ? 16'sd0 : az;
                end
                send_sample(ax, ay, az, 1'b0, nul, ph != 7);
            end
        end
        smp_if.valid <= 1'b0;

        timer = 0;
        while (angle_queue.size() != 0 && timer < WATCHDOG_MAX) begin
            @(posedge i_clk);
            timer++;
        end
        stim_done = 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (angle_queue.size() != 0) begin
            $display("%0t %0d expected transactions never arrived", $time, angle_queue.size());
            n_errors++;
        end
        $display("Covered %0d samples, %0d angle transactions, all eight smoothing shifts,",
                 n_samples, n_angles);
        $display("axis extremes, zero vectors and a long output stall; %0d errors", n_errors);
        if (n_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
